>>> hdl/sequential_array_list_top_defines.svh
// Assertion macros shared by the sequential array list RTL.
// Used by sal_ctrl; expects clk and rst_n in the including scope.
`ifndef SEQUENTIAL_ARRAY_LIST_TOP_DEFINES_SVH
`define SEQUENTIAL_ARRAY_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sal_pkg.sv
// Package for the sequential array list: sizes, request/status codes, FSM states.
// No dependencies.
package sal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 4;
  localparam int ECNT_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEARCH    = 3'd0,
    REQ_INS_POS   = 3'd1,
    REQ_INS_FRONT = 3'd2,
    REQ_INS_END   = 3'd3,
    REQ_DELETE    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_NEG    = 3'd2,
    ST_BEYOND = 3'd3,
    ST_ABSENT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_PUT
  } state_t;

  // Result of one finished request, handed to the output stage
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [FIDX_W-1:0]   found_index;
    logic [ECNT_W-1:0]   entry_count;
  } res_t;

endpackage

>>> hdl/sal_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sal_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/sal_ctrl.sv
// Request sequencer for the sequential array list: scans and shifts the key RAM.
// Depends on sal_pkg and sequential_array_list_top_defines.svh.
`include "sequential_array_list_top_defines.svh"

module sal_ctrl
  import sal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [REQ_W-1:0]        req,
  input  logic [KEY_W-1:0]        key,
  input  logic [POS_W-1:0]        position,
  output logic                    busy,
  output logic                    rd_en,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic [KEY_W-1:0]        rd_data,
  output logic                    wr_en,
  output logic [IDX_W-1:0]        wr_addr,
  output logic [KEY_W-1:0]        wr_data,
  output res_t                    res
);

  localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

  state_t             state_r,   state_nxt;
  logic [CNT_W-1:0]   cnt_r,     cnt_nxt;
  req_t               req_r,     req_nxt;
  logic [KEY_W-1:0]   key_r,     key_nxt;
  logic [CNT_W-1:0]   rd_ptr_r,  rd_ptr_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   src_r,     src_nxt;
  logic [IDX_W-1:0]   target_r,  target_nxt;
  logic [IDX_W-1:0]   found_r,   found_nxt;

  req_t               req_in;
  logic [POS_W-2:0]   pos_mag;
  logic               full;
  logic               ins_go;
  logic [CNT_W-1:0]   ins_target;
  logic [IDX_W-1:0]   res_idx;

  assign req_in  = req_t'(req);
  assign pos_mag = position[POS_W-2:0];
  assign full    = (cnt_r >= CNT_W'(CAPACITY));
  assign busy    = (state_r != S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    src_r     <= src_nxt;
    target_r  <= target_nxt;
    found_r   <= found_nxt;
  end

  // Next state, RAM accesses and result
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    rd_ptr_nxt  = rd_ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    src_nxt     = src_r;
    target_nxt  = target_r;
    found_nxt   = found_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    ins_go      = 1'b0;
    ins_target  = '0;
    res_idx     = '0;
    res.valid   = 1'b0;
    res.status  = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req_in;
          key_nxt = key;
          unique case (req_in) inside
            REQ_SEARCH, REQ_DELETE: begin
              if (cnt_r == '0) begin
                res.valid  = 1'b1;
                res.status = ST_ABSENT;
              end else begin
                // first read; the compare happens next cycle
                rd_en       = 1'b1;
                rd_addr     = '0;
                rd_ptr_nxt  = CNT_W'(1);
                cmp_idx_nxt = '0;
                state_nxt   = S_SCAN;
              end
            end
            REQ_INS_POS: begin
              if (full) begin
                res.valid  = 1'b1;
                res.status = ST_FULL;
              end else if (position[POS_W-1]) begin
                res.valid  = 1'b1;
                res.status = ST_NEG;
              end else if (CMP_W'(pos_mag) > CMP_W'(cnt_r)) begin
                res.valid  = 1'b1;
                res.status = ST_BEYOND;
              end else begin
                ins_go     = 1'b1;
                ins_target = CNT_W'(pos_mag);
              end
            end
            REQ_INS_FRONT: begin
              if (full) begin
                res.valid  = 1'b1;
                res.status = ST_FULL;
              end else begin
                ins_go     = 1'b1;
                ins_target = '0;
              end
            end
            REQ_INS_END: begin
              if (full) begin
                res.valid  = 1'b1;
                res.status = ST_FULL;
              end else begin
                ins_go     = 1'b1;
                ins_target = cnt_r;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              res.valid = 1'b1;
            end
            default: begin
              // unused codes answer ok and change nothing
              res.valid = 1'b1;
            end
          endcase

          // Start an insert: append directly, or shift the tail up first
          if (ins_go) begin
            target_nxt = IDX_W'(ins_target);
            if (ins_target == cnt_r) begin
              state_nxt = S_PUT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(cnt_r - CNT_W'(1));
              src_nxt   = IDX_W'(cnt_r - CNT_W'(1));
              state_nxt = S_SHUP;
            end
          end
        end
      end

      S_SCAN: begin
        // rd_data holds the entry at cmp_idx_r
        if (rd_data == key_r) begin
          res_idx = cmp_idx_r;
          if (req_r == REQ_DELETE) begin
            found_nxt = cmp_idx_r;
            if (CNT_W'(cmp_idx_r) + CNT_W'(1) == cnt_r) begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              res.valid = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = cmp_idx_r + IDX_W'(1);
              src_nxt   = cmp_idx_r + IDX_W'(1);
              state_nxt = S_SHDN;
            end
          end else begin
            res.valid = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (rd_ptr_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_addr     = IDX_W'(rd_ptr_r);
          cmp_idx_nxt = IDX_W'(rd_ptr_r);
          rd_ptr_nxt  = rd_ptr_r + CNT_W'(1);
        end else begin
          res.valid  = 1'b1;
          res.status = ST_ABSENT;
          state_nxt  = S_IDLE;
        end
      end

      S_SHDN: begin
        // move entry src_r down one place, fetch the next one
        wr_en   = 1'b1;
        wr_addr = src_r - IDX_W'(1);
        wr_data = rd_data;
        res_idx = found_r;
        if (CNT_W'(src_r) + CNT_W'(1) < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = src_r + IDX_W'(1);
          src_nxt = src_r + IDX_W'(1);
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SHUP: begin
        // move entry src_r up one place, walking toward the target
        wr_en   = 1'b1;
        wr_addr = src_r + IDX_W'(1);
        wr_data = rd_data;
        if (src_r > target_r) begin
          rd_en   = 1'b1;
          rd_addr = src_r - IDX_W'(1);
          src_nxt = src_r - IDX_W'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = target_r;
        wr_data   = key_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        res.valid = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.found_index = FIDX_W'(res_idx);
    res.entry_count = ECNT_W'(cnt_nxt);
  end

  // Checks on the sequencer
  `SAL_ASSERT_NOW(a_no_rw_same_entry, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same entry")
  `SAL_ASSERT_NOW(a_shdn_needs_two, state_r == S_SHDN, cnt_r >= CNT_W'(2), "shift down with fewer than two live entries")
  `SAL_ASSERT_NOW(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= cnt_r, "write beyond the live range")
  `SAL_ASSERT_NEXT(a_put_counts, state_r == S_PUT, cnt_r == $past(cnt_r) + CNT_W'(1), "insert did not bump the count")

endmodule

>>> hdl/sequential_array_list_top.sv
// Top level of the sequential array list: ports, key RAM, sequencer, result register.
// Depends on sal_pkg, sal_ram and sal_ctrl.
//
// Usage:
//   An item (in_req_type, in_key, in_position) is taken at a rising edge with
//   start high and busy low. busy stays high while the sequencer walks the list.
//   Each item gives exactly one result, shown for one cycle with out_valid high
//   on out_status, out_found_index and out_entry_count. The receiver cannot
//   stall; results must be taken in the cycle they appear.
// Steps per item (n = live entries, p = insert position, i = index of the match):
//   search        : reads entries 0 to i in turn (all n when absent)
//   delete        : scans as search, then moves entries i + 1 to n - 1 down one place
//   insert        : shifts entries p to n - 1 up, then writes key; at end, write only
//   clear, errors : answered at once, without touching the key RAM
//   The pace is set by the single read port of the key RAM: one entry is
//   read per cycle while scanning or shifting. A new item may be started in
//   the cycle its predecessor's result is shown.
// Reset (rst_n low, synchronous) empties the list and returns to idle; the key
// RAM is not cleared, since only live entries are ever read.
module sequential_array_list_top
  import sal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic signed [POS_W-1:0]  in_position,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [FIDX_W-1:0]        out_found_index,
  output logic [ECNT_W-1:0]        out_entry_count
);

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  res_t             res;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FIDX_W-1:0]   out_found_index_r;
  logic [ECNT_W-1:0]   out_entry_count_r;

  // Key storage
  sal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request sequencer
  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (in_req_type),
    .key      (in_key),
    .position (in_position),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res      (res)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  // Result payload, loaded when an item finishes
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r      <= res.status;
      out_found_index_r <= res.found_index;
      out_entry_count_r <= res.entry_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_index_r;
  assign out_entry_count = out_entry_count_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the sequential array list (sequential_array_list_top).
// Depends on sal_pkg; keeps its own copy of the list to predict every result.
`timescale 1ns / 1ps

module testbench
  import sal_pkg::*;
();

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_GAP = 20;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct {
    status_t           status;
    logic [FIDX_W-1:0] found_index;
    logic [ECNT_W-1:0] entry_count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [POS_W-1:0] in_position = '0;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [FIDX_W-1:0]       out_found_index;
  logic [ECNT_W-1:0]       out_entry_count;

  // Shadow copy of the list
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  int               shadow_count = 0;

  list_result_t     pending_results [$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               sender_idle_pct = 0;
  logic [KEY_W-1:0] key_pool [8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                                     32'h7fff_ffff, 32'h5, 32'h5555_5555, 32'haaaa_aaaa};

  sequential_array_list_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

  // Clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Open a slot at pos, shifting the tail up by one
  function automatic void shadow_insert(input int pos, input logic [KEY_W-1:0] key);
    for (int j = shadow_count; j > pos; j--) shadow_keys[j] = shadow_keys[j-1];
    shadow_keys[pos] = key;
    shadow_count++;
  endfunction

  // Apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_list_request(input logic [REQ_W-1:0] req,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [POS_W-1:0] pos);
    list_result_t r;
    int           hit;
    r.status      = ST_OK;
    r.found_index = '0;
    hit = -1;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_keys[i] == key) hit = i;
    end
    case (req)
      REQ_SEARCH: begin
        if (hit < 0) r.status = ST_ABSENT;
        else r.found_index = hit[FIDX_W-1:0];
      end
      REQ_INS_POS: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else if (pos[POS_W-1]) r.status = ST_NEG;
        else if (int'(pos) > shadow_count) r.status = ST_BEYOND;
        else shadow_insert(int'(pos), key);
      end
      REQ_INS_FRONT: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else shadow_insert(0, key);
      end
      REQ_INS_END: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else shadow_insert(shadow_count, key);
      end
      REQ_DELETE: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.found_index = hit[FIDX_W-1:0];
          for (int j = hit; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
          shadow_count--;
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.entry_count = shadow_count[ECNT_W-1:0];
    return r;
  endfunction

  // Send one item; start is left high so a back-to-back item needs no toggle
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_list_request(req, key, pos));
  endtask

  // Compare each result with the oldest pending one
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d index %0d count %0d",
                                  out_status, out_found_index, out_entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d", out_found_index,
                                    want.found_index));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count,
                                    want.entry_count));
      end
    end
  end

  // Requests on an empty list and position checks
  task automatic test_empty_list();
    send_request(REQ_SEARCH, 32'h0, 8'd0);
    send_request(REQ_DELETE, KEY_MIN, 8'd0);
    send_request(REQ_INS_POS, 32'h1, 8'd1);
    send_request(REQ_INS_POS, 32'h1, 8'h80);
    send_request(REQ_INS_POS, 32'h1, 8'hff);
  endtask

  // Extreme keys, insert at count, far positions, search and delete hits
  task automatic test_extreme_keys();
    send_request(REQ_INS_POS, KEY_MIN, 8'd0);
    send_request(REQ_INS_FRONT, KEY_MAX, 8'd0);
    send_request(REQ_INS_END, 32'hffff_ffff, 8'd0);
    send_request(REQ_INS_POS, 32'h0, 8'd3);
    send_request(REQ_INS_POS, 32'h2, 8'd127);
    send_request(REQ_SEARCH, KEY_MIN, 8'd0);
    send_request(REQ_DELETE, KEY_MAX, 8'd0);
    send_request(REQ_SEARCH, 32'h0, 8'd0);
  endtask

  // Unused codes are ignored; clear keeps nothing live
  task automatic test_unused_and_clear();
    send_request(REQ_UNUSED_LO, KEY_MIN, 8'h80);
    send_request(REQ_UNUSED_HI, KEY_MAX, 8'h7f);
    send_request(REQ_CLEAR, 32'h0, 8'd0);
    send_request(REQ_SEARCH, KEY_MIN, 8'd0);
  endtask

  // Fill to capacity, then every insert must report full; then delete the last and first entries
  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++) send_request(REQ_INS_END, 32'(i * 3), 8'd0);
    send_request(REQ_INS_POS, 32'h9, 8'hff);
    send_request(REQ_INS_FRONT, 32'h9, 8'd0);
    send_request(REQ_INS_END, 32'h9, 8'd0);
    send_request(REQ_DELETE, 32'(3 * (CAPACITY - 1)), 8'd0);
    send_request(REQ_DELETE, 32'h0, 8'd0);
  endtask

  // Random mix weighted toward matching keys and in-range positions
  task automatic test_random_requests(input int idle_pct, input int n_items);
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    int               pick;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 24) req = REQ_SEARCH;
      else if (pick < 36) req = REQ_INS_POS;
      else if (pick < 48) req = REQ_INS_FRONT;
      else if (pick < 60) req = REQ_INS_END;
      else if (pick < 92) req = REQ_DELETE;
      else if (pick < 96) req = REQ_CLEAR;
      else req = ($urandom_range(1) != 0) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      if ($urandom_range(9) < 8) key = key_pool[$urandom_range(7)];
      else key = $urandom;
      pick = $urandom_range(9);
      if (pick < 7) pos = 8'($urandom_range(shadow_count));
      else if (pick == 7) pos = 8'(shadow_count + 1);
      else pos = 8'($urandom_range(255));
      send_request(req, key, pos);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    shadow_count = 0;
    for (int i = 0; i < CAPACITY; i++) shadow_keys[i] = '0;

    sender_idle_pct = 24;
    test_empty_list();
    test_extreme_keys();
    test_unused_and_clear();
    test_full_list();
    test_random_requests(24, 200);
    test_random_requests(66, 200);
    test_random_requests(0, 200);

    // Drain: wait for every pending result, then a little longer
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
